// File: rtl/assert_macros.svh
// Assertion helper macros used by the checker file cpf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: rtl/cpf_pkg.sv
// ---------------------------------------------------------------------------
// cpf_pkg
// Shared types, register map and CRC16 helper functions of the packet framer.
// ---------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

    // Register map: register index is byte address divided by four
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLYNOMIAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INITIAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_REFLECT_IN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_REFLECT_OUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_XOR_OUT     = 3'd6;

    // Reset values of the configuration registers
    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

    // Input word kinds (carried on tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef struct packed {
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_initial;
        logic        crc_reflect_in;
        logic        crc_reflect_out;
        logic [15:0] crc_xor_out;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  packet_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_beat_t;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] mirror16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    // One byte of MSB-first CRC16, eight shift steps
    function automatic logic [15:0] crc16_byte(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly,
        input logic        refl_in
    );
        logic [15:0] c;
        logic [7:0]  d;
        d = refl_in ? mirror8(data) : data;
        c = crc ^ {d, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cpf_cfg_regs.sv
// ---------------------------------------------------------------------------
// cpf_cfg_regs
// APB register file holding header bytes and CRC16 settings.
// ---------------------------------------------------------------------------
`default_nettype none

module cpf_cfg_regs
    import cpf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output cfg_t                       cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first    <= 8'h00;
            cfg_reg.header_second   <= 8'h00;
            cfg_reg.crc_polynomial  <= CRC_POLY_RESET;
            cfg_reg.crc_initial     <= CRC_INIT_RESET;
            cfg_reg.crc_reflect_in  <= 1'b0;
            cfg_reg.crc_reflect_out <= 1'b0;
            cfg_reg.crc_xor_out     <= 16'h0000;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEADER_FIRST:    cfg_reg.header_first    <= pwdata[7:0];
                REG_HEADER_SECOND:   cfg_reg.header_second   <= pwdata[7:0];
                REG_CRC_POLYNOMIAL:  cfg_reg.crc_polynomial  <= pwdata[15:0];
                REG_CRC_INITIAL:     cfg_reg.crc_initial     <= pwdata[15:0];
                REG_CRC_REFLECT_IN:  cfg_reg.crc_reflect_in  <= pwdata[0];
                REG_CRC_REFLECT_OUT: cfg_reg.crc_reflect_out <= pwdata[0];
                REG_CRC_XOR_OUT:     cfg_reg.crc_xor_out     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_HEADER_FIRST:    prdata = {24'h0, cfg_reg.header_first};
            REG_HEADER_SECOND:   prdata = {24'h0, cfg_reg.header_second};
            REG_CRC_POLYNOMIAL:  prdata = {16'h0, cfg_reg.crc_polynomial};
            REG_CRC_INITIAL:     prdata = {16'h0, cfg_reg.crc_initial};
            REG_CRC_REFLECT_IN:  prdata = {31'h0, cfg_reg.crc_reflect_in};
            REG_CRC_REFLECT_OUT: prdata = {31'h0, cfg_reg.crc_reflect_out};
            REG_CRC_XOR_OUT:     prdata = {16'h0, cfg_reg.crc_xor_out};
            default:             prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cpf_framer_core.sv
// ---------------------------------------------------------------------------
// cpf_framer_core
// Holds the input word and steps through its output bytes, one per cycle
// unless stalled; keeps sequence number, running CRC, payload bytes left.
// ---------------------------------------------------------------------------
`default_nettype none

module cpf_framer_core
    import cpf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       beat_valid,
    input  wire logic  beat_ready,
    output out_beat_t  beat
);

    // Byte steps of a start word
    localparam logic [2:0] ST_HDR_FIRST  = 3'd0;
    localparam logic [2:0] ST_HDR_SECOND = 3'd1;
    localparam logic [2:0] ST_SEQUENCE   = 3'd2;
    localparam logic [2:0] ST_TYPE       = 3'd3;
    localparam logic [2:0] ST_LEN_LOW    = 3'd4;
    localparam logic [2:0] ST_LEN_HIGH   = 3'd5;
    localparam logic [2:0] ST_CRC_LOW    = 3'd6;
    localparam logic [2:0] ST_CRC_HIGH   = 3'd7;
    // Byte steps of a data word
    localparam logic [2:0] DT_PAYLOAD    = 3'd0;
    localparam logic [2:0] DT_CRC_LOW    = 3'd1;
    localparam logic [2:0] DT_CRC_HIGH   = 3'd2;

    logic        item_valid_reg;
    item_t       item_reg;
    logic [2:0]  step_reg;
    logic [7:0]  seq_reg;
    logic [15:0] crc_reg;
    logic [15:0] rem_reg;
    logic        open_reg;

    logic        is_start;
    logic [15:0] crc_fin;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic [7:0]  byte_sel;
    logic        absorb;
    logic        last_step;
    logic        frame_end;
    logic        drop;
    logic        fire;
    logic        item_done;
    logic        accept;

    assign is_start = (item_reg.cmd == CMD_START);
    assign crc_fin  = (cfg.crc_reflect_out ? mirror16(crc_reg) : crc_reg) ^ cfg.crc_xor_out;

    // Select the byte for the current step
    always_comb begin
        byte_sel  = 8'h00;
        absorb    = 1'b0;
        last_step = 1'b0;
        frame_end = 1'b0;
        drop      = 1'b0;
        if (is_start) begin
            case (step_reg)
                ST_HDR_FIRST: begin
                    byte_sel = cfg.header_first;
                    absorb   = 1'b1;
                end
                ST_HDR_SECOND: begin
                    byte_sel = cfg.header_second;
                    absorb   = 1'b1;
                end
                ST_SEQUENCE: begin
                    byte_sel = seq_reg;
                    absorb   = 1'b1;
                end
                ST_TYPE: begin
                    byte_sel = item_reg.packet_type;
                    absorb   = 1'b1;
                end
                ST_LEN_LOW: begin
                    byte_sel = item_reg.payload_length[7:0];
                    absorb   = 1'b1;
                end
                ST_LEN_HIGH: begin
                    byte_sel  = item_reg.payload_length[15:8];
                    absorb    = 1'b1;
                    last_step = (item_reg.payload_length != 16'h0000);
                end
                ST_CRC_LOW: begin
                    byte_sel = crc_fin[7:0];
                end
                ST_CRC_HIGH: begin
                    byte_sel  = crc_fin[15:8];
                    frame_end = 1'b1;
                    last_step = 1'b1;
                end
                default: begin
                    last_step = 1'b1;
                end
            endcase
        end else if (!open_reg) begin
            // no frame open: drop the payload word
            drop = item_valid_reg;
        end else begin
            case (step_reg)
                DT_PAYLOAD: begin
                    byte_sel  = item_reg.data_byte;
                    absorb    = 1'b1;
                    last_step = (rem_reg != 16'h0001);
                end
                DT_CRC_LOW: begin
                    byte_sel = crc_fin[7:0];
                end
                DT_CRC_HIGH: begin
                    byte_sel  = crc_fin[15:8];
                    frame_end = 1'b1;
                    last_step = 1'b1;
                end
                default: begin
                    last_step = 1'b1;
                end
            endcase
        end
    end

    assign crc_base = (is_start && step_reg == ST_HDR_FIRST) ? cfg.crc_initial : crc_reg;
    assign crc_upd  = crc16_byte(crc_base, byte_sel, cfg.crc_polynomial, cfg.crc_reflect_in);

    assign beat_valid     = item_valid_reg && !drop;
    assign beat.out_byte  = byte_sel;
    assign beat.frame_end = frame_end;

    assign fire      = beat_valid && beat_ready;
    assign item_done = item_valid_reg && (drop || (fire && last_step));
    assign in_ready  = !item_valid_reg || item_done;
    assign accept    = in_valid && in_ready;

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
    end

    // Advance steps and update frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            step_reg       <= 3'd0;
            seq_reg        <= 8'h00;
            crc_reg        <= 16'h0000;
            rem_reg        <= 16'h0000;
            open_reg       <= 1'b0;
        end else begin
            if (accept) begin
                item_valid_reg <= 1'b1;
                step_reg       <= 3'd0;
            end else if (item_done) begin
                item_valid_reg <= 1'b0;
                step_reg       <= 3'd0;
            end else if (fire) begin
                step_reg <= step_reg + 3'd1;
            end

            if (fire && absorb) begin
                crc_reg <= crc_upd;
            end
            if (fire && is_start && step_reg == ST_SEQUENCE) begin
                seq_reg <= seq_reg + 8'h01;
            end
            if (fire && is_start && step_reg == ST_LEN_HIGH) begin
                rem_reg  <= item_reg.payload_length;
                open_reg <= (item_reg.payload_length != 16'h0000);
            end
            if (fire && !is_start && step_reg == DT_PAYLOAD) begin
                rem_reg <= rem_reg - 16'h0001;
            end
            if (fire && frame_end) begin
                open_reg <= 1'b0;
                rem_reg  <= 16'h0000;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/cpf_out_stage.sv
// ---------------------------------------------------------------------------
// cpf_out_stage
// Output register of the framed byte stream; takes a new word whenever the
// held one leaves or none is held.
// ---------------------------------------------------------------------------
`default_nettype none

module cpf_out_stage
    import cpf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire out_beat_t in_beat,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_beat_t      out_beat
);

    logic      out_valid_reg;
    out_beat_t out_beat_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            out_beat_reg <= in_beat;
        end
    end

endmodule

`default_nettype wire

// File: rtl/crc16_packet_framer_unit.sv
// ---------------------------------------------------------------------------
// crc16_packet_framer_unit
// Frames payload bytes with a six-byte header and a configurable CRC16.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[0] = 0 opens a frame (tdata carries type and length),
//   tuser[0] = 1 carries one payload byte. Master stream: one framed byte per
//   word, tlast on the high CRC byte that closes a frame.
//   Configure header bytes and CRC settings over APB while the block is idle.
// Path: the bytes of an accepted word pass the core's word register and then
//   the output register before they reach the master side.
// Throughput: one output byte per cycle while m_tready is high, set by the
//   byte stepper in the framer core. A payload word gives one byte (three
//   when it ends the frame), a start word six bytes (eight for a zero-length
//   frame). A payload word with no open frame is dropped without output.
// Reset: clears sequence number, frame state, CRC and both stream registers;
//   registers return to their reset values.
// Stall: when m_tready is low the output register holds its word, the core
//   stops stepping and s_tready falls once the core holds a word to send.
// ---------------------------------------------------------------------------
`default_nettype none

module crc16_packet_framer_unit
    import cpf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // packet_type[7:0], payload_length[23:8],
                                                  // data_byte[31:24]
    input  wire logic [0:0]            s_tuser,   // cmd[0]
    // Framed output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [7:0]            m_tdata,   // out_byte[7:0]
    output logic                       m_tlast
);

    cfg_t      cfg;
    item_t     s_item;
    out_beat_t core_beat;
    out_beat_t m_beat;
    logic      core_valid;
    logic      core_ready;

    assign pready = 1'b1;

    assign s_item.cmd            = s_tuser[0];
    assign s_item.packet_type    = s_tdata[7:0];
    assign s_item.payload_length = s_tdata[23:8];
    assign s_item.data_byte      = s_tdata[31:24];

    assign m_tdata = m_beat.out_byte;
    assign m_tlast = m_beat.frame_end;

    cpf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    cpf_framer_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .beat_valid (core_valid),
        .beat_ready (core_ready),
        .beat       (core_beat)
    );

    cpf_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .in_beat   (core_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (m_beat)
    );

endmodule

`default_nettype wire

// File: rtl/cpf_checker.sv
// ---------------------------------------------------------------------------
// cpf_checker
// Port-level checks of the packet framer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpf_checker
    import cpf_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // Hold a stalled output word
    `ASSERT_CLK_RST(a_m_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK_RST(a_m_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    // Output register is empty right after reset
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // A start word keeps the input blocked while its header goes out
    `ASSERT_CLK_RST(a_start_blocks, aclk, aresetn, s_tvalid && s_tready && s_tuser[0] == CMD_START |=> !s_tready)

endmodule

bind crc16_packet_framer_unit cpf_checker u_cpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for crc16_packet_framer_unit: drives start and payload
// words with bursty timing, writes CRC and header settings over APB between
// phases, predicts every framed byte and compares the result stream in order.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import cpf_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_GUARD   = 20000;
    localparam int PRINT_CAP    = 40;

    // Frame predictor and in-order byte checker
    class framer_scoreboard;
        cfg_t        regs;
        logic [7:0]  seq_num;
        logic [15:0] crc_acc;
        logic [15:0] left;
        bit          in_frame;
        int          fail_count;
        out_beat_t   framed_bytes[$];

        function new();
            regs                = '0;
            regs.crc_polynomial = CRC_POLY_RESET;
            regs.crc_initial    = CRC_INIT_RESET;
            seq_num             = '0;
            crc_acc             = '0;
            left                = '0;
            in_frame            = 1'b0;
            fail_count          = 0;
        endfunction

        task report(string msg);
            // keep the log short if the block is badly broken
            if (fail_count < PRINT_CAP) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            fail_count++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_HEADER_FIRST:    regs.header_first    = value[7:0];
                REG_HEADER_SECOND:   regs.header_second   = value[7:0];
                REG_CRC_POLYNOMIAL:  regs.crc_polynomial  = value[15:0];
                REG_CRC_INITIAL:     regs.crc_initial     = value[15:0];
                REG_CRC_REFLECT_IN:  regs.crc_reflect_in  = value[0];
                REG_CRC_REFLECT_OUT: regs.crc_reflect_out = value[0];
                REG_CRC_XOR_OUT:     regs.crc_xor_out     = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] reverse_bits(logic [15:0] v, int width);
            logic [15:0] r;
            r = '0;
            for (int i = 0; i < width; i++) begin
                r = {r[14:0], v[i]};
            end
            return r;
        endfunction

        // Fold one byte into the running CRC, MSB first
        function void absorb(logic [7:0] b);
            logic [7:0] d;
            d = b;
            if (regs.crc_reflect_in) begin
                d = 8'(reverse_bits({8'h00, b}, 8));
            end
            crc_acc = crc_acc ^ {d, 8'h00};
            repeat (8) begin
                if (crc_acc[15]) begin
                    crc_acc = {crc_acc[14:0], 1'b0} ^ regs.crc_polynomial;
                end else begin
                    crc_acc = {crc_acc[14:0], 1'b0};
                end
            end
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            out_beat_t ob;
            ob.out_byte  = b;
            ob.frame_end = last;
            framed_bytes = {framed_bytes, ob};
        endfunction

        function void put_data(logic [7:0] b);
            absorb(b);
            push_byte(b, 1'b0);
        endfunction

        // Append the finalized CRC, low byte first, and close the frame
        function void close_frame();
            logic [15:0] c;
            c = crc_acc;
            if (regs.crc_reflect_out) begin
                c = reverse_bits(c, 16);
            end
            c = c ^ regs.crc_xor_out;
            push_byte(c[7:0], 1'b0);
            push_byte(c[15:8], 1'b1);
            in_frame = 1'b0;
            left     = '0;
        endfunction

        // Predict the bytes caused by one accepted word; returns their count
        function int note_word(item_t w);
            int before_n;
            before_n = framed_bytes.size();
            if (w.cmd == CMD_START) begin
                crc_acc = regs.crc_initial;
                put_data(regs.header_first);
                put_data(regs.header_second);
                put_data(seq_num);
                put_data(w.packet_type);
                put_data(w.payload_length[7:0]);
                put_data(w.payload_length[15:8]);
                seq_num++;
                left     = w.payload_length;
                in_frame = 1'b1;
                if (left == 0) begin
                    close_frame();
                end
            end else if (in_frame) begin
                put_data(w.data_byte);
                left--;
                if (left == 0) begin
                    close_frame();
                end
            end
            return framed_bytes.size() - before_n;
        endfunction

        task check_byte(logic [7:0] b, logic last);
            out_beat_t want;
            if (framed_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h tlast %0b", b, last));
            end else begin
                want = framed_bytes.pop_front();
                if (b !== want.out_byte) begin
                    report($sformatf("byte %02h, expected %02h", b, want.out_byte));
                end
                if (last !== want.frame_end) begin
                    report($sformatf("tlast %0b on byte %02h, expected %0b",
                                     last, b, want.frame_end));
                end
            end
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;  // packet_type[7:0], payload_length[23:8],
                                           // data_byte[31:24]
    logic [0:0]            s_tuser  = '0;  // cmd[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // out_byte[7:0]
    logic                  m_tlast;

    framer_scoreboard sb;
    int               burst_left   = 1;
    int               words_counted = 0;
    int               holds_asked  = 0;

    crc16_packet_framer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Check every accepted output word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_byte(m_tdata, m_tlast);
        end
    end

    // Receiver: segments of free flow, random stalls and a sparse pattern,
    // plus a long hold-off whenever the stimulus asks for one
    initial begin
        int  seg_left;
        int  mode;
        int  hold_left;
        int  holds_served;
        int  cyc;
        bit  ready_now;
        seg_left     = 0;
        mode         = 0;
        hold_left    = 0;
        holds_served = 0;
        cyc          = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                ready_now = 1'b0;
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 60);
                    mode     = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0:       ready_now = 1'b1;
                    1:       ready_now = 1'($urandom_range(0, 1));
                    default: ready_now = (cyc % 4 == 0);
                endcase
            end
            cyc++;
            m_tready <= ready_now;
            @(posedge aclk);
        end
    end

    // Offer one word, hold it until accepted, then note it for prediction
    task send_word(item_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= {w.data_byte, w.payload_length, w.packet_type};
        s_tuser  <= w.cmd;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_word(w) > 0) begin
            words_counted++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(40, 80);
            end else begin
                burst_left = $urandom_range(1, 10);
            end
        end
    endtask

    task send_start(logic [7:0] ptype, logic [15:0] plen);
        item_t w;
        w.cmd            = CMD_START;
        w.packet_type    = ptype;
        w.payload_length = plen;
        w.data_byte      = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task send_payload(logic [7:0] b);
        item_t w;
        w.cmd            = CMD_DATA;
        w.packet_type    = 8'($urandom_range(0, 255));
        w.payload_length = 16'($urandom_range(0, 65535));
        w.data_byte      = b;
        send_word(w);
    endtask

    // Drop tvalid, wait for all predicted bytes, then let the core settle
    task wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.framed_bytes.size() != 0 && guard < IDLE_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        if (sb.framed_bytes.size() != 0) begin
            sb.report($sformatf("%0d predicted bytes never arrived",
                                sb.framed_bytes.size()));
            sb.framed_bytes.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task write_settings(logic [7:0] h1, logic [7:0] h2, logic [15:0] poly,
                        logic [15:0] init, logic rin, logic rout, logic [15:0] xo);
        reg_write(REG_HEADER_FIRST, {24'h0, h1});
        reg_write(REG_HEADER_SECOND, {24'h0, h2});
        reg_write(REG_CRC_POLYNOMIAL, {16'h0, poly});
        reg_write(REG_CRC_INITIAL, {16'h0, init});
        reg_write(REG_CRC_REFLECT_IN, {31'h0, rin});
        reg_write(REG_CRC_REFLECT_OUT, {31'h0, rout});
        reg_write(REG_CRC_XOR_OUT, {16'h0, xo});
    endtask

    // Mostly well-formed frames with random content; some abandoned frames
    // and stray payload words as noise
    task random_traffic(int n_items, int zero_pct);
        int goal;
        int pick;
        int len;
        goal = words_counted + n_items;
        while (words_counted < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if ($urandom_range(0, 99) < zero_pct) begin
                    len = 0;
                end else if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(9, 24);
                end else begin
                    len = $urandom_range(1, 8);
                end
                send_start(8'($urandom_range(0, 255)), 16'(len));
                repeat (len) send_payload(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                send_start(8'($urandom_range(0, 255)), 16'($urandom_range(4, 65535)));
                repeat ($urandom_range(0, 3)) send_payload(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_payload(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under reset settings: stray payload, zero length,
        // shortest frames, field extremes, a start inside an open frame
        send_payload(8'h00);
        send_payload(8'hFF);
        send_start(8'h00, 16'd0);
        send_start(8'hFF, 16'd1);
        send_payload(8'hFF);
        send_start(8'h5A, 16'd2);
        send_payload(8'h00);
        send_payload(8'h80);
        send_payload(8'h3C);
        send_start(8'h01, 16'hFFFF);
        send_payload(8'h12);
        send_payload(8'h34);
        send_start(8'hA5, 16'd3);
        send_payload(8'hC3);
        wait_idle();

        // Change every setting with the frame still open, then finish it
        write_settings(8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF);
        send_payload(8'h7E);
        send_payload(8'h81);
        send_payload(8'hE7);
        holds_asked++;
        random_traffic(60, 20);
        wait_idle();

        write_settings(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000);
        random_traffic(50, 20);
        wait_idle();

        write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'h8005,
                       16'h0000, 1'b1, 1'b1, 16'h0000);
        holds_asked++;
        random_traffic(60, 20);
        wait_idle();

        // Random settings; mostly zero-length frames
        write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       16'($urandom_range(0, 65535)));
        random_traffic(40, 70);
        wait_idle();

        if (sb.fail_count == 0) begin
            $display("crc16_packet_framer_unit verification clean");
        end else begin
            $display("crc16_packet_framer_unit verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #3200000;
        $display("crc16_packet_framer_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/cpf_pkg.sv
rtl/cpf_cfg_regs.sv
rtl/cpf_framer_core.sv
rtl/cpf_out_stage.sv
rtl/crc16_packet_framer_unit.sv
rtl/cpf_checker.sv
test/testbench.sv
